[rtl/core/pdcs_pkg.sv]
// ----------------------------------------------------------------------------
// pdcs_pkg: shared types and constants of the packet deframer
// phase codes, record kinds and the command passed from parser to reporter
// ----------------------------------------------------------------------------
package pdcs_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h00;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT0   = 3'd0,
        PH_HUNT1   = 3'd1,
        PH_ID      = 3'd2,
        PH_SEQLO   = 3'd3,
        PH_SEQHI   = 3'd4,
        PH_SIZE    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CHECK   = 3'd7
    } t_phase;

    // classified word handed from the parser to the reporter
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_id;
        logic [15:0] packet_seq;
        logic [7:0]  payload_len;
        logic        cs_bad;
        logic        seq_bad;
    } t_cmd;

    // result word as driven on the output channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_id;
        logic [15:0] packet_seq;
        logic [7:0]  payload_len;
        logic [1:0]  status;
        logic [31:0] accepted_count;
        logic [31:0] loss_count;
        logic [31:0] corrupt_count;
    } t_rec;

endpackage

[rtl/core/pdcs_if.sv]
// ----------------------------------------------------------------------------
// pdcs_if: stream channels of the packet deframer
// input byte channel and output record channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface pdcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pdcs_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_id;
    logic [15:0] packet_seq;
    logic [7:0]  payload_len;
    logic [1:0]  status;
    logic [31:0] accepted_count;
    logic [31:0] loss_count;
    logic [31:0] corrupt_count;

    modport source (
        output valid, output kind, output payload_byte, output packet_id,
        output packet_seq, output payload_len, output status,
        output accepted_count, output loss_count, output corrupt_count,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input packet_id,
        input packet_seq, input payload_len, input status,
        input accepted_count, input loss_count, input corrupt_count,
        output ready
    );
endinterface

[rtl/core/pdcs_front.sv]
// ----------------------------------------------------------------------------
// pdcs_front: frame parser
// hunts for the sync word, tracks the header and checksum, classifies words
// ----------------------------------------------------------------------------
module pdcs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pdcs_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output pdcs_pkg::t_cmd o_cmd
);

    pdcs_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_id;
    logic [15:0] r_seq;
    logic [7:0]  r_len;
    logic [7:0]  r_left;
    logic [7:0]  r_sum;
    logic [15:0] r_prev_seq;
    logic        r_have_prev;
    logic        w_fire;
    logic [7:0]  w_byte;
    logic [15:0] w_seq_next;

    assign i_in.ready = !i_full;
    assign w_fire     = i_in.valid && !i_full;
    assign w_byte     = i_in.data_byte;
    assign w_seq_next = r_prev_seq + 16'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            unique case (r_phase)
                pdcs_pkg::PH_HUNT0:
                    n_phase = (w_byte == pdcs_pkg::SYNC_BYTE) ? pdcs_pkg::PH_HUNT1
                                                               : pdcs_pkg::PH_HUNT0;
                pdcs_pkg::PH_HUNT1:
                    n_phase = (w_byte == pdcs_pkg::SYNC_BYTE) ? pdcs_pkg::PH_ID
                                                               : pdcs_pkg::PH_HUNT0;
                pdcs_pkg::PH_ID:    n_phase = pdcs_pkg::PH_SEQLO;
                pdcs_pkg::PH_SEQLO: n_phase = pdcs_pkg::PH_SEQHI;
                pdcs_pkg::PH_SEQHI: n_phase = pdcs_pkg::PH_SIZE;
                pdcs_pkg::PH_SIZE:
                    n_phase = (w_byte == 8'd0) ? pdcs_pkg::PH_CHECK
                                               : pdcs_pkg::PH_PAYLOAD;
                pdcs_pkg::PH_PAYLOAD:
                    n_phase = (r_left == 8'd1) ? pdcs_pkg::PH_CHECK
                                               : pdcs_pkg::PH_PAYLOAD;
                pdcs_pkg::PH_CHECK: n_phase = pdcs_pkg::PH_HUNT0;
                default:            n_phase = pdcs_pkg::PH_HUNT0;
            endcase
        end
    end

    // classified word toward the queue
    always_comb begin
        o_push             = 1'b0;
        o_cmd.kind         = pdcs_pkg::KIND_PAYLOAD;
        o_cmd.payload_byte = w_byte;
        o_cmd.packet_id    = r_id;
        o_cmd.packet_seq   = r_seq;
        o_cmd.payload_len  = r_len;
        o_cmd.cs_bad       = (w_byte != r_sum);
        o_cmd.seq_bad      = r_have_prev && (w_seq_next != r_seq);
        unique case (r_phase)
            pdcs_pkg::PH_PAYLOAD: o_push = w_fire;
            pdcs_pkg::PH_CHECK: begin
                o_push             = w_fire;
                o_cmd.kind         = pdcs_pkg::KIND_STATUS;
                o_cmd.payload_byte = 8'd0;
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pdcs_pkg::PH_HUNT0;
            r_id        <= '0;
            r_seq       <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_sum       <= '0;
            r_prev_seq  <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_fire) begin
                case (r_phase)
                    pdcs_pkg::PH_ID: begin
                        r_id  <= w_byte;
                        r_sum <= w_byte;
                    end
                    pdcs_pkg::PH_SEQLO: begin
                        r_seq <= {8'd0, w_byte};
                        r_sum <= r_sum + w_byte;
                    end
                    pdcs_pkg::PH_SEQHI: begin
                        r_seq[15:8] <= w_byte;
                        r_sum       <= r_sum + w_byte;
                    end
                    pdcs_pkg::PH_SIZE: begin
                        r_len  <= w_byte;
                        r_left <= w_byte;
                        r_sum  <= r_sum + w_byte;
                    end
                    pdcs_pkg::PH_PAYLOAD: begin
                        r_left <= r_left - 8'd1;
                        r_sum  <= r_sum + w_byte;
                    end
                    pdcs_pkg::PH_CHECK: begin
                        r_prev_seq  <= r_seq;
                        r_have_prev <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[rtl/core/pdcs_queue.sv]
// ----------------------------------------------------------------------------
// pdcs_queue: short command queue
// decouples the parser from the reporter, first word shown combinationally
// ----------------------------------------------------------------------------
module pdcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pdcs_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output pdcs_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    localparam int unsigned PW = pdcs_pkg::QUEUE_PTR_W;

    pdcs_pkg::t_cmd r_mem [pdcs_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == (PW+1)'(pdcs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/pdcs_back.sv]
// ----------------------------------------------------------------------------
// pdcs_back: status reporter
// keeps the saturating packet counters and drives the output register
// ----------------------------------------------------------------------------
module pdcs_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pdcs_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    pdcs_out_if.source     o_out
);

    localparam int unsigned VW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [COUNT_WIDTH-1:0] r_acc, n_acc;
    logic [COUNT_WIDTH-1:0] r_loss, n_loss;
    logic [COUNT_WIDTH-1:0] r_corr, n_corr;
    logic                   r_valid;
    pdcs_pkg::t_rec         r_rec, n_rec;
    logic                   w_status;

    function automatic logic [COUNT_WIDTH-1:0] f_sat_inc(
        input logic [COUNT_WIDTH-1:0] v
    );
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // clamp to the 32-bit reported range
    function automatic logic [31:0] f_view(input logic [COUNT_WIDTH-1:0] v);
        logic [VW-1:0] ext;
        ext = VW'(v);
        return (ext > VW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];
    endfunction

    assign o_pop    = !i_empty && (!r_valid || o_out.ready);
    assign w_status = (i_cmd.kind == pdcs_pkg::KIND_STATUS);

    always_comb begin
        n_acc  = r_acc;
        n_loss = r_loss;
        n_corr = r_corr;
        if (w_status) begin
            if (!i_cmd.cs_bad) n_acc  = f_sat_inc(r_acc);
            if (i_cmd.seq_bad) n_loss = f_sat_inc(r_loss);
            if (i_cmd.cs_bad)  n_corr = f_sat_inc(r_corr);
        end
        n_rec.kind           = i_cmd.kind;
        n_rec.payload_byte   = i_cmd.payload_byte;
        n_rec.packet_id      = i_cmd.packet_id;
        n_rec.packet_seq     = i_cmd.packet_seq;
        n_rec.payload_len    = i_cmd.payload_len;
        n_rec.status         = w_status ? {i_cmd.seq_bad, i_cmd.cs_bad} : 2'd0;
        n_rec.accepted_count = f_view(n_acc);
        n_rec.loss_count     = f_view(n_loss);
        n_rec.corrupt_count  = f_view(n_corr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_loss  <= '0;
            r_corr  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_acc   <= n_acc;
                r_loss  <= n_loss;
                r_corr  <= n_corr;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= n_rec;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_rec.kind;
    assign o_out.payload_byte   = r_rec.payload_byte;
    assign o_out.packet_id      = r_rec.packet_id;
    assign o_out.packet_seq     = r_rec.packet_seq;
    assign o_out.payload_len    = r_rec.payload_len;
    assign o_out.status         = r_rec.status;
    assign o_out.accepted_count = r_rec.accepted_count;
    assign o_out.loss_count     = r_rec.loss_count;
    assign o_out.corrupt_count  = r_rec.corrupt_count;

endmodule

[rtl/core/packet_deframer_checksum_sequence.sv]
// ----------------------------------------------------------------------------
// packet_deframer_checksum_sequence: sync-word deframer with checksum check
// top level: parser, command queue and status reporter
// ----------------------------------------------------------------------------
// Takes one raw byte per word on i_in and accepts a new byte every cycle as
// long as the four-entry command queue between parser and reporter has room;
// a stalled output only holds the input off once that queue fills. Frames are
// two zero sync bytes, id, sequence (low byte first), size, payload and an
// 8-bit additive checksum over everything after the sync word. Each payload
// byte comes out as a payload record (kind 0) and each checksum byte as a
// status record (kind 1) with status bit 0 for a checksum mismatch and bit 1
// for a sequence break (sequence not previous plus one, first packet always
// good). Header and sync bytes give no record. A record reaches o_out through
// the queue and the output register: its byte is written into the queue when
// it is accepted, and it moves into the output register when the reporter
// pops it, which waits while a stalled output record is held. The three
// saturating counters are COUNT_WIDTH bits wide and are reported clamped to
// 32 bits; payload records carry the counts before the packet, status
// records the counts including it. A failed packet is still reported and
// counted, and hunting for sync resumes after it.
// ----------------------------------------------------------------------------
module packet_deframer_checksum_sequence #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdcs_in_if.sink    i_in,
    pdcs_out_if.source o_out
);

    pdcs_pkg::t_cmd w_push_cmd;
    pdcs_pkg::t_cmd w_head_cmd;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    // frame parser: sync hunt, header capture, running checksum
    pdcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // short queue so parser and reporter stall independently
    pdcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // counters and output register
    pdcs_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

[rtl/core/pdcs_checker.sv]
// ----------------------------------------------------------------------------
// pdcs_checker: port-level assertions of the packet deframer
// bound to the top level, watches the output channel only
// ----------------------------------------------------------------------------
module pdcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [7:0]  i_out_payload_byte,
    input logic [1:0]  i_out_status,
    input logic [31:0] i_out_accepted_count,
    input logic [31:0] i_out_loss_count,
    input logic [31:0] i_out_corrupt_count
);

    // payload records never carry a status
    a_payload_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == pdcs_pkg::KIND_PAYLOAD) |-> i_out_status == 2'd0)
        else $error("payload record with nonzero status");

    // status records never carry a payload byte
    a_status_payload_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == pdcs_pkg::KIND_STATUS) |-> i_out_payload_byte == 8'd0)
        else $error("status record with nonzero payload byte");

    // the counter matching a reported status already includes this packet
    a_status_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == pdcs_pkg::KIND_STATUS) |->
            (i_out_status[0] ? (i_out_corrupt_count != 32'd0)
                             : (i_out_accepted_count != 32'd0)) &&
            (!i_out_status[1] || (i_out_loss_count != 32'd0)))
        else $error("status record not reflected in counters");

    // a stalled record holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
            $stable(i_out_status) && $stable(i_out_payload_byte))
        else $error("output record changed while stalled");

endmodule

bind packet_deframer_checksum_sequence pdcs_checker u_pdcs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_kind           (o_out.kind),
    .i_out_payload_byte   (o_out.payload_byte),
    .i_out_status         (o_out.status),
    .i_out_accepted_count (o_out.accepted_count),
    .i_out_loss_count     (o_out.loss_count),
    .i_out_corrupt_count  (o_out.corrupt_count)
);

[dv/pdcs_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdcs_record_checker: record checker for the packet deframer
// watches both channels, tracks the frame state on every accepted input word
// and compares each output word field by field with the oldest prediction
// ----------------------------------------------------------------------------
module pdcs_record_checker #(
    parameter int unsigned COUNT_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  pdcs_pkg::t_rec i_out_rec,
    output int unsigned    o_fail_count,
    output int unsigned    o_pending,
    output int unsigned    o_payload_count,
    output int unsigned    o_status_count
);

    localparam logic [1:0]  ST_CS_BAD  = 2'b01;
    localparam logic [1:0]  ST_SEQ_BAD = 2'b10;
    localparam logic [63:0] CNT_MAX    =
        (COUNT_W >= 64) ? {64{1'b1}} : ((64'd1 << COUNT_W) - 64'd1);

    // frame tracking state
    pdcs_pkg::t_phase frm_phase;
    logic [7:0]       frm_id;
    logic [15:0]      frm_seq;
    logic [7:0]       frm_len;
    logic [7:0]       frm_left;
    logic [7:0]       frm_sum;
    logic [15:0]      last_seq;
    bit               seen_frame;
    logic [63:0]      n_accepted;
    logic [63:0]      n_lost;
    logic [63:0]      n_corrupt;

    pdcs_pkg::t_rec   expected_recs[$];

    function automatic logic [63:0] sat_inc(input logic [63:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic pdcs_pkg::t_rec make_rec(input logic kind,
                                                input logic [7:0] pbyte,
                                                input logic [1:0] st);
        pdcs_pkg::t_rec r;
        r.kind           = kind;
        r.payload_byte   = pbyte;
        r.packet_id      = frm_id;
        r.packet_seq     = frm_seq;
        r.payload_len    = frm_len;
        r.status         = st;
        r.accepted_count = clamp32(n_accepted);
        r.loss_count     = clamp32(n_lost);
        r.corrupt_count  = clamp32(n_corrupt);
        return r;
    endfunction

    // advance the frame state by one byte, queue the record it produces
    task automatic deframe_byte(input logic [7:0] b);
        logic [1:0] st;
        case (frm_phase)
            pdcs_pkg::PH_HUNT0:
                frm_phase = (b == pdcs_pkg::SYNC_BYTE) ? pdcs_pkg::PH_HUNT1
                                                       : pdcs_pkg::PH_HUNT0;
            pdcs_pkg::PH_HUNT1:
                frm_phase = (b == pdcs_pkg::SYNC_BYTE) ? pdcs_pkg::PH_ID
                                                       : pdcs_pkg::PH_HUNT0;
            pdcs_pkg::PH_ID: begin
                frm_id    = b;
                frm_sum   = b;
                frm_phase = pdcs_pkg::PH_SEQLO;
            end
            pdcs_pkg::PH_SEQLO: begin
                frm_seq   = {8'h00, b};
                frm_sum   = frm_sum + b;
                frm_phase = pdcs_pkg::PH_SEQHI;
            end
            pdcs_pkg::PH_SEQHI: begin
                frm_seq[15:8] = b;
                frm_sum       = frm_sum + b;
                frm_phase     = pdcs_pkg::PH_SIZE;
            end
            pdcs_pkg::PH_SIZE: begin
                frm_len   = b;
                frm_left  = b;
                frm_sum   = frm_sum + b;
                frm_phase = (b == 8'h00) ? pdcs_pkg::PH_CHECK : pdcs_pkg::PH_PAYLOAD;
            end
            pdcs_pkg::PH_PAYLOAD: begin
                frm_sum  = frm_sum + b;
                frm_left = frm_left - 8'd1;
                if (frm_left == 8'h00) frm_phase = pdcs_pkg::PH_CHECK;
                expected_recs.push_back(make_rec(pdcs_pkg::KIND_PAYLOAD, b, 2'b00));
            end
            default: begin
                st = 2'b00;
                if (b != frm_sum) st |= ST_CS_BAD;
                if (seen_frame && (last_seq + 16'd1) != frm_seq) st |= ST_SEQ_BAD;
                if ((st & ST_CS_BAD) == 2'b00) n_accepted = sat_inc(n_accepted);
                if ((st & ST_SEQ_BAD) != 2'b00) n_lost = sat_inc(n_lost);
                if ((st & ST_CS_BAD) != 2'b00) n_corrupt = sat_inc(n_corrupt);
                last_seq   = frm_seq;
                seen_frame = 1'b1;
                frm_phase  = pdcs_pkg::PH_HUNT0;
                expected_recs.push_back(make_rec(pdcs_pkg::KIND_STATUS, 8'h00, st));
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        pdcs_pkg::t_rec want;
        if (!i_rst_n) begin
            frm_phase       = pdcs_pkg::PH_HUNT0;
            frm_id          = 8'h00;
            frm_seq         = 16'h0000;
            frm_len         = 8'h00;
            frm_left        = 8'h00;
            frm_sum         = 8'h00;
            last_seq        = 16'h0000;
            seen_frame      = 1'b0;
            n_accepted      = '0;
            n_lost          = '0;
            n_corrupt       = '0;
            o_fail_count    = 0;
            o_payload_count = 0;
            o_status_count  = 0;
            expected_recs.delete();
            o_pending      <= 0;
        end else begin
            if (i_in_valid && i_in_ready) deframe_byte(i_in_byte);
            if (i_out_valid && i_out_ready) begin
                if (expected_recs.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected word, expected none, actual %0h",
                             $time, i_out_rec);
                end else begin
                    want = expected_recs.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_out_rec.kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_out_rec.payload_byte));
                    check_field("packet_id", 32'(want.packet_id),
                                32'(i_out_rec.packet_id));
                    check_field("packet_seq", 32'(want.packet_seq),
                                32'(i_out_rec.packet_seq));
                    check_field("payload_len", 32'(want.payload_len),
                                32'(i_out_rec.payload_len));
                    check_field("status", 32'(want.status), 32'(i_out_rec.status));
                    check_field("accepted_count", want.accepted_count,
                                i_out_rec.accepted_count);
                    check_field("loss_count", want.loss_count, i_out_rec.loss_count);
                    check_field("corrupt_count", want.corrupt_count,
                                i_out_rec.corrupt_count);
                    if (want.kind == pdcs_pkg::KIND_STATUS) o_status_count++;
                    else o_payload_count++;
                end
            end
            o_pending <= expected_recs.size();
        end
    end

endmodule

[dv/packet_deframer_checksum_sequence_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_deframer_checksum_sequence_test: stream test of the packet deframer
// drives directed and random frames mixed with noise through the byte channel
// under random bursts and output stalls; pdcs_record_checker predicts every
// record
// ----------------------------------------------------------------------------
module packet_deframer_checksum_sequence_test;

    // narrow counter width
    localparam int unsigned CNT_W = 8;

    // receiver stall modes
    localparam int unsigned RX_FREE   = 0;
    localparam int unsigned RX_LIGHT  = 1;
    localparam int unsigned RX_HEAVY  = 2;
    localparam int unsigned RX_BURSTY = 3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdcs_in_if  in_if ();
    pdcs_out_if out_if ();

    pdcs_pkg::t_rec out_word;
    int unsigned    fail_count;
    int unsigned    pending;
    int unsigned    payload_seen;
    int unsigned    status_seen;

    // sender bookkeeping
    int unsigned tx_burst = 0;    // words left in the current burst
    bit          tx_calm  = 1'b0; // no gaps while set
    int unsigned words_sent;
    int unsigned frame_words;
    int unsigned frames_sent;
    int unsigned good_frames;
    int unsigned bad_frames;

    // receiver pattern state
    int unsigned rx_mode = RX_FREE;
    int unsigned rx_span = 0;

    always #5 i_clk = ~i_clk;

    packet_deframer_checksum_sequence #(
        .COUNT_WIDTH(CNT_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // output channel packed in record field order for the checker
    assign out_word = {out_if.kind, out_if.payload_byte, out_if.packet_id,
                       out_if.packet_seq, out_if.payload_len, out_if.status,
                       out_if.accepted_count, out_if.loss_count,
                       out_if.corrupt_count};

    pdcs_record_checker #(
        .COUNT_W(CNT_W)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_if.valid),
        .i_in_ready      (in_if.ready),
        .i_in_byte       (in_if.data_byte),
        .i_out_valid     (out_if.valid),
        .i_out_ready     (out_if.ready),
        .i_out_rec       (out_word),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_payload_count (payload_seen),
        .o_status_count  (status_seen)
    );

    // receiver: switches between stall modes after a random span
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_BURSTY);
            rx_span = $urandom_range(8, 120);
        end
        rx_span = rx_span - 1;
        case (rx_mode)
            RX_FREE:  out_if.ready <= 1'b1;
            RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
            default:  out_if.ready <= ((rx_span % 24) < 16);   // long periodic stall
        endcase
    end

    // one word on the byte channel; a new burst may open with a gap
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (tx_burst == 0) begin
            tx_burst = $urandom_range(1, 24);
            if (!tx_calm) gap = $urandom_range(1, 6);
        end
        tx_burst--;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // full frame: sync word, header, payload and checksum
    // fill < 0 gives random payload, otherwise every payload byte is fill
    task automatic send_frame(input logic [7:0] id, input logic [15:0] seq,
                              input int unsigned len, input int fill,
                              input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] pb;
        push_byte(pdcs_pkg::SYNC_BYTE);
        push_byte(pdcs_pkg::SYNC_BYTE);
        push_byte(id);
        push_byte(seq[7:0]);
        push_byte(seq[15:8]);
        push_byte(len[7:0]);
        sum = id + seq[7:0] + seq[15:8] + len[7:0];
        for (int i = 0; i < len; i++) begin
            pb  = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            sum = sum + pb;
            push_byte(pb);
        end
        // a single flipped bit makes the checksum wrong
        if (bad_sum) sum = sum ^ (8'd1 << $urandom_range(0, 7));
        push_byte(sum);
        frames_sent++;
        frame_words += len + 7;
        if (bad_sum) bad_frames++;
        else good_frames++;
    endtask

    initial begin
        int unsigned pick;
        int unsigned iter;
        int unsigned len;
        int unsigned nbytes;
        logic [15:0] next_seq;
        logic [15:0] seq;

        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= 8'h00;
        words_sent  = 0;
        frame_words = 0;
        frames_sent = 0;
        good_frames = 0;
        bad_frames  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        // broken sync: one zero then a nonzero byte restarts the hunt
        push_byte(pdcs_pkg::SYNC_BYTE);
        push_byte(8'h7F);
        // third zero is taken as the id, top sequence, empty payload, first frame
        send_frame(8'h00, 16'hFFFF, 0, 0, 1'b0);
        // sequence wraps to zero, all-ones id and payload, bad checksum
        send_frame(8'hFF, 16'h0000, 1, 255, 1'b1);
        // sequence jump with a good checksum
        send_frame(8'h81, 16'h0005, 0, 0, 1'b0);
        next_seq = 16'h0006;

        // random part: mostly well-formed frames, some noise and cut frames
        iter = 0;
        while (words_sent < 1900) begin
            if ((iter % 32) == 0) tx_calm = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                // payload length mostly short, the largest at most twice
                if (frames_sent == 60 || frames_sent == 180) len = 255;
                else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)      len = 0;
                    else if (pick < 85) len = $urandom_range(1, 3);
                    else                len = $urandom_range(4, 12);
                end
                pick = $urandom_range(0, 99);
                if (pick < 85)      seq = next_seq;
                else if (pick < 90) seq = next_seq - 16'd1;
                else                seq = 16'($urandom_range(0, 65535));
                send_frame(8'($urandom_range(0, 255)), seq, len, -1,
                           ($urandom_range(0, 99) < 8));
                next_seq = seq + 16'd1;
            end else if (pick < 92) begin
                // noise between frames, zeros now and then
                nbytes = $urandom_range(1, 5);
                repeat (nbytes) begin
                    if ($urandom_range(0, 3) == 0) push_byte(pdcs_pkg::SYNC_BYTE);
                    else push_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                // frame cut short after the sync word and part of the header
                push_byte(pdcs_pkg::SYNC_BYTE);
                push_byte(pdcs_pkg::SYNC_BYTE);
                nbytes = $urandom_range(0, 3);
                repeat (nbytes) push_byte(8'($urandom_range(0, 255)));
            end
            iter++;
        end
        // a clean closing frame leaves the parser hunting
        send_frame(8'h5A, next_seq, 2, -1, 1'b0);
        in_if.valid <= 1'b0;

        // drain: pending is a registered copy of the prediction queue size
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d words: %0d frames (%0d with bad checksum), noise, cut frames",
                 words_sent, frames_sent, bad_frames);
        $display("checked %0d payload words and %0d status words, counters %0d bits wide",
                 payload_seen, status_seen, CNT_W);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pdcs_pkg.sv
rtl/core/pdcs_if.sv
rtl/core/pdcs_front.sv
rtl/core/pdcs_queue.sv
rtl/core/pdcs_back.sv
rtl/core/packet_deframer_checksum_sequence.sv
rtl/core/pdcs_checker.sv
dv/pdcs_checker.sv
dv/packet_deframer_checksum_sequence_test.sv
